// File: rtl/core/pstb_pkg.sv
`timescale 1ns / 1ps

package pstb_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;

  localparam int unsigned IP_W       = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned INTERVAL_W = 30;
  localparam int unsigned CAPACITY_W = 16;
  localparam int unsigned DIV_W      = 32;   // divisor / remainder width
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 30'd200000000;
  localparam logic [CAPACITY_W-1:0] CAPACITY_RST = 16'd10;

  // register select is paddr[2]
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [IP_W-1:0]       tag;
    logic [CAPACITY_W-1:0] tokens;
    logic [TIME_W-1:0]     last;
  } entry_t;

endpackage

// File: rtl/core/pstb_ram.sv
`timescale 1ns / 1ps

module pstb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/core/pstb_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pstb_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pstb_pkg::TIME_W-1:0] num_i,
  input  logic [pstb_pkg::DIV_W-1:0]  den_i,
  output logic                        done_o,
  output logic [pstb_pkg::TIME_W-1:0] quo_o,
  output logic [pstb_pkg::DIV_W-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(pstb_pkg::TIME_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [pstb_pkg::TIME_W-1:0] quo_q;
  logic [pstb_pkg::DIV_W-1:0]  rem_q;
  logic [pstb_pkg::DIV_W-1:0]  den_q;

  logic [pstb_pkg::DIV_W:0]    trial;
  logic [pstb_pkg::DIV_W:0]    diff;
  logic                        ge;

  assign trial = {rem_q, quo_q[pstb_pkg::TIME_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(pstb_pkg::TIME_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pstb_pkg::TIME_W-2:0], ge};
      rem_q <= ge ? diff[pstb_pkg::DIV_W-1:0] : trial[pstb_pkg::DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/per_source_token_bucket_limiter_unit.sv
`timescale 1ns / 1ps

// Per-source token bucket limiter. One item at a time: a check item goes
// through a table read, a bit-serial divide of elapsed time by the refill
// interval and a write-back when TABLE_ENTRIES is a power of two; otherwise
// the slot index first comes from a reciprocal multiply, a back-multiply
// and one correction step.
// A clear item sweeps the table.
// After reset the same sweep runs before the first item is taken;
// configuration writes are taken at any time. The next item
// is accepted while a result still waits on a stalled output.
module per_source_token_bucket_limiter_unit #(
  parameter int unsigned TABLE_ENTRIES = pstb_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [pstb_pkg::IP_W-1:0]       source_ip_i,
  input  logic [pstb_pkg::TIME_W-1:0]     now_time_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            allowed_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pstb_pkg::APB_AW-1:0]     paddr,
  input  logic [pstb_pkg::APB_DW-1:0]     pwdata,
  output logic [pstb_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned IdxW    = $clog2(TABLE_ENTRIES);
  localparam bit          IsPow2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  // floor(2^32 / TABLE_ENTRIES): quotient estimate is exact or one low
  localparam logic [pstb_pkg::IP_W-1:0] ModRecip =
    pstb_pkg::IP_W'((64'd1 << 32) / TABLE_ENTRIES);
  localparam logic [pstb_pkg::IP_W-1:0] ModDen = pstb_pkg::IP_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_MODX, ST_LOOK, ST_CALC, ST_DIVW, ST_DONE
  } state_e;

  state_e state_q;

  // config
  logic [pstb_pkg::INTERVAL_W-1:0] interval_q;
  logic [pstb_pkg::CAPACITY_W-1:0] capacity_q;
  logic                            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == pstb_pkg::REG_CAPACITY)
                ? {{(pstb_pkg::APB_DW - pstb_pkg::CAPACITY_W){1'b0}}, capacity_q}
                : {{(pstb_pkg::APB_DW - pstb_pkg::INTERVAL_W){1'b0}}, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= pstb_pkg::INTERVAL_RST;
      capacity_q <= pstb_pkg::CAPACITY_RST;
    end else if (cfg_we) begin
      if (paddr[2] == pstb_pkg::REG_CAPACITY) begin
        capacity_q <= pwdata[pstb_pkg::CAPACITY_W-1:0];
      end else begin
        interval_q <= pwdata[pstb_pkg::INTERVAL_W-1:0];
      end
    end
  end

  // item registers
  logic                            clr_item_q;
  logic [pstb_pkg::IP_W-1:0]       ip_q;
  logic [pstb_pkg::TIME_W-1:0]     now_q;
  logic [IdxW-1:0]                 idx_q;
  logic [IdxW-1:0]                 sweep_q;
  logic [pstb_pkg::CAPACITY_W-1:0] tok_q;
  logic [pstb_pkg::TIME_W-1:0]     last_q;
  logic                            res_q;
  logic                            out_valid_q;
  logic                            out_valid_d;
  logic                            out_load;
  logic                            allowed_q;
  logic [1:0]                      mstep_q;
  logic [pstb_pkg::IP_W-1:0]       mq_q;
  logic [pstb_pkg::IP_W-1:0]       mr_q;
  logic [2*pstb_pkg::IP_W-1:0]     mod_prod;
  logic [pstb_pkg::IP_W-1:0]       mod_back;

  // table
  logic [IdxW-1:0]        ram_addr;
  logic                   ram_we;
  pstb_pkg::entry_t       ram_wdata;
  pstb_pkg::entry_t       ram_rdata;

  pstb_ram #(
    .WIDTH ($bits(pstb_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // divider
  logic                        div_start;
  logic [pstb_pkg::TIME_W-1:0] div_num;
  logic [pstb_pkg::DIV_W-1:0]  div_den;
  logic                        div_done;
  logic [pstb_pkg::TIME_W-1:0] div_quo;
  logic [pstb_pkg::DIV_W-1:0]  div_rem;

  pstb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  logic                            in_acc;
  logic                            hit;
  logic [pstb_pkg::CAPACITY_W-1:0] rd_tok;
  logic [pstb_pkg::TIME_W-1:0]     rd_last;
  logic [pstb_pkg::INTERVAL_W-1:0] step;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // new or evicted source starts empty at time zero
  assign hit     = ram_rdata.valid && (ram_rdata.tag == ip_q);
  assign rd_tok  = hit ? ram_rdata.tokens : '0;
  assign rd_last = hit ? ram_rdata.last : '0;
  assign step    = (interval_q == '0) ? pstb_pkg::INTERVAL_W'(1) : interval_q;

  assign div_start = (state_q == ST_CALC);
  assign div_num   = now_q - rd_last;
  assign div_den   = {{(pstb_pkg::DIV_W - pstb_pkg::INTERVAL_W){1'b0}}, step};

  // slot index for a table size that is not a power of two
  assign mod_prod = {{pstb_pkg::IP_W{1'b0}}, ip_q} * {{pstb_pkg::IP_W{1'b0}}, ModRecip};
  assign mod_back = mq_q * ModDen;

  // refill and consume
  logic                            refill;
  logic                            sat;
  logic [pstb_pkg::CAPACITY_W:0]   sum;
  logic [pstb_pkg::CAPACITY_W-1:0] sum_c;
  logic [pstb_pkg::CAPACITY_W-1:0] new_tok;
  logic [pstb_pkg::TIME_W-1:0]     new_last;
  logic                            allow;

  assign refill   = |div_quo;
  assign sat      = div_quo >= {{(pstb_pkg::TIME_W - pstb_pkg::CAPACITY_W){1'b0}}, capacity_q};
  assign sum      = {1'b0, tok_q} + {1'b0, div_quo[pstb_pkg::CAPACITY_W-1:0]};
  assign sum_c    = (sum > {1'b0, capacity_q}) ? capacity_q : sum[pstb_pkg::CAPACITY_W-1:0];
  assign new_tok  = !refill ? tok_q : (sat ? capacity_q : sum_c);
  assign new_last = refill
                  ? now_q - {{(pstb_pkg::TIME_W - pstb_pkg::DIV_W){1'b0}}, div_rem}
                  : last_q;
  assign allow    = new_tok != '0;

  always_comb begin
    ram_addr  = idx_q;
    ram_we    = 1'b0;
    ram_wdata = '{valid: 1'b1, tag: ip_q,
                  tokens: allow ? new_tok - 1'b1 : new_tok, last: new_last};
    if (state_q == ST_SWEEP) begin
      ram_addr        = sweep_q;
      ram_we          = 1'b1;
      ram_wdata.valid = 1'b0;
    end else if (state_q == ST_DIVW && div_done) begin
      ram_we = 1'b1;
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      clr_item_q  <= 1'b0;
      sweep_q     <= '0;
      mstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == LastIdx) begin
            sweep_q <= '0;
            state_q <= clr_item_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            mstep_q <= '0;
            if (op_i == pstb_pkg::OP_CLEAR) begin
              clr_item_q <= 1'b1;
              state_q    <= ST_SWEEP;
            end else begin
              clr_item_q <= 1'b0;
              state_q    <= IsPow2 ? ST_LOOK : ST_MODX;
            end
          end
        end
        ST_MODX: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd2) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: state_q <= ST_CALC;
        ST_CALC: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ip_q  <= source_ip_i;
      now_q <= now_time_i;
      idx_q <= source_ip_i[IdxW-1:0];
      res_q <= 1'b0;
    end
    if (state_q == ST_MODX) begin
      if (mstep_q == 2'd0) begin
        mq_q <= mod_prod[2*pstb_pkg::IP_W-1:pstb_pkg::IP_W];
      end
      if (mstep_q == 2'd1) begin
        mr_q <= ip_q - mod_back;
      end
      if (mstep_q == 2'd2) begin
        idx_q <= (mr_q >= ModDen) ? IdxW'(mr_q - ModDen) : IdxW'(mr_q);
      end
    end
    if (state_q == ST_CALC) begin
      tok_q  <= rd_tok;
      last_q <= rd_last;
    end
    if (state_q == ST_DIVW && div_done) begin
      res_q <= allow;
    end
    if (out_load) begin
      allowed_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;

  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVW)
    else $error("divider finished outside a divide state");

  a_look_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |=> state_q == ST_CALC)
    else $error("table read not followed by calc");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
    else $error("finished item not presented");

endmodule
